/* hw/rtl/rlbr_pkg.sv */
// types, constants and helpers shared by the receive line buffer ring
`default_nettype none
package rlbr_pkg;

  localparam int LINE_BYTES = 64;
  localparam int LINE_SLOTS = 5;

  localparam int SLOT_W = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
  localparam int LEN_W  = $clog2(LINE_BYTES + 1);
  localparam int ADDR_W = $clog2(LINE_SLOTS * LINE_BYTES);

  localparam logic [7:0] NEWLINE = 8'h0A;

  localparam logic [1:0] MODE_RX    = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_LINE   = 2'd1;
  localparam logic [1:0] ST_REFUSE = 2'd2;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam int OB_DEPTH = 4;
  localparam int OB_PTR_W = $clog2(OB_DEPTH);
  localparam int OB_CNT_W = $clog2(OB_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_DONE   = 2'd0,
    CMD_REFUSE = 2'd1,
    CMD_POP    = 2'd2
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE   = 1'b0,
    BK_STREAM = 1'b1
  } back_state_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               we;
    logic [7:0]         data;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
    logic               ready;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] line_byte;
    logic       last;
    logic       line_ready;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_flags_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(LINE_SLOTS - 1)) begin
      return '0;
    end
    return s + SLOT_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
    return ADDR_W'(s) * ADDR_W'(LINE_BYTES);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/receive_line_buffer_ring_core.sv */
// top level of the receive line buffer ring
// Collects received bytes into a ring of line slots and hands complete lines out.
// Request channel: mode and rx_byte, taken when push is high and full is low.
//   mode 0 stores a byte, mode 1 pops the oldest complete line, mode 2 empties all
//   slots. Result channel: status, line_byte, last and line_ready are valid while
//   empty is low and are taken when pop is high.
// A byte, clear or refused pop gives one result; a line pop gives one result per
// line byte, with last set on the final one.
// Path: a request passes through the command queue, the p1 read stage and the result
//   buffer, whose head drives the result ports.
// Throughput: one request per cycle for bytes, clears and refused pops while the
//   result buffer has room; a line pop holds the back end until every line byte is
//   read via the single read port of the line store; requests queue up to four deep.
// Reset clears all slot lengths, both slot pointers and both queues; the line
//   store itself is not cleared, so there is no start-up pass.
// When the receiver holds pop low the result buffer fills, the back end pauses,
//   then the command queue fills and full rises; nothing is dropped.
`default_nettype none
module receive_line_buffer_ring_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] rx_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      status,
  output logic [7:0]      line_byte,
  output logic            last,
  output logic            line_ready
);
  import rlbr_pkg::*;

  cmd_t         cq_din;
  cmd_t         cq_dout;
  logic         cq_push;
  logic         cq_pop;
  queue_flags_t cq_flags;
  result_t      result;

  rlbr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .mode     (mode),
    .rx_byte  (rx_byte),
    .cq_flags (cq_flags),
    .cq_push  (cq_push),
    .cq_din   (cq_din)
  );

  rlbr_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cq_push),
    .din   (cq_din),
    .pop   (cq_pop),
    .dout  (cq_dout),
    .flags (cq_flags)
  );

  rlbr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cq_dout  (cq_dout),
    .cq_flags (cq_flags),
    .cq_pop   (cq_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

  assign status     = result.status;
  assign line_byte  = result.line_byte;
  assign last       = result.last;
  assign line_ready = result.line_ready;

endmodule
`default_nettype wire

/* hw/rtl/rlbr_front.sv */
// front end: accepts requests, keeps slot bookkeeping and issues commands
`default_nettype none
module rlbr_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [1:0]          mode,
  input  wire logic [7:0]          rx_byte,
  input  wire rlbr_pkg::queue_flags_t cq_flags,
  output logic                     cq_push,
  output rlbr_pkg::cmd_t           cq_din
);
  import rlbr_pkg::*;

  logic [LEN_W-1:0]  slot_len      [LINE_SLOTS];
  logic [LEN_W-1:0]  slot_len_next [LINE_SLOTS];
  logic [LINE_SLOTS-1:0] slot_nl;
  logic [LINE_SLOTS-1:0] slot_nl_next;
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] wr_slot_next;
  logic [SLOT_W-1:0] rd_slot;
  logic [SLOT_W-1:0] rd_slot_next;

  logic              accept;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  len_inc;
  logic [SLOT_W-1:0] wr_adv;
  logic              rd_ok;

  assign full    = cq_flags.full;
  assign accept  = push && !cq_flags.full;
  assign cq_push = accept;

  always_comb begin
    slot_len_next = slot_len;
    slot_nl_next  = slot_nl;
    wr_slot_next  = wr_slot;
    rd_slot_next  = rd_slot;
    len_eff = (slot_len[wr_slot] >= LEN_W'(LINE_BYTES)) ? '0 : slot_len[wr_slot];
    len_inc = len_eff + LEN_W'(1);
    wr_adv  = next_slot(wr_slot);
    rd_ok   = (slot_len[rd_slot] != '0) && slot_nl[rd_slot];
    cq_din  = '0;
    cq_din.kind = CMD_DONE;
    case (mode)
      MODE_RX: begin
        cq_din.we   = 1'b1;
        cq_din.data = rx_byte;
        cq_din.addr = slot_base(wr_slot) + ADDR_W'(len_eff);
        slot_nl_next[wr_slot] = (rx_byte == NEWLINE);
        if ((rx_byte == NEWLINE) && (len_inc > LEN_W'(1))) begin
          slot_len_next[wr_slot] = len_inc;
          wr_slot_next           = wr_adv;
          slot_len_next[wr_adv]  = '0;
        end else begin
          slot_len_next[wr_slot] = (len_inc == LEN_W'(LINE_BYTES)) ? '0 : len_inc;
        end
      end
      MODE_POP: begin
        if (rd_ok) begin
          cq_din.kind            = CMD_POP;
          cq_din.addr            = slot_base(rd_slot);
          cq_din.len             = slot_len[rd_slot];
          slot_len_next[rd_slot] = '0;
          rd_slot_next           = next_slot(rd_slot);
        end else begin
          cq_din.kind = CMD_REFUSE;
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < LINE_SLOTS; i++) begin
          slot_len_next[i] = '0;
        end
      end
      default: begin
      end
    endcase
    cq_din.ready = (slot_len_next[rd_slot_next] != '0) && slot_nl_next[rd_slot_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINE_SLOTS; i++) begin
        slot_len[i] <= '0;
      end
      slot_nl <= '0;
      wr_slot <= '0;
      rd_slot <= '0;
    end else if (accept) begin
      slot_len <= slot_len_next;
      slot_nl  <= slot_nl_next;
      wr_slot  <= wr_slot_next;
      rd_slot  <= rd_slot_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rlbr_cmd_queue.sv */
// command queue between the front end and the back end
`default_nettype none
module rlbr_cmd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rlbr_pkg::cmd_t  din,
  input  wire logic            pop,
  output rlbr_pkg::cmd_t       dout,
  output rlbr_pkg::queue_flags_t flags
);
  import rlbr_pkg::*;

  cmd_t                entry [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_CNT_W-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign flags.full  = (count == CQ_CNT_W'(CQ_DEPTH));
  assign flags.empty = (count == '0);
  assign do_push     = push && !flags.full;
  assign do_pop      = pop && !flags.empty;
  assign dout        = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + CQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + CQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CQ_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rlbr_back.sv */
// back end: line store, line streaming and result buffer
`default_nettype none
module rlbr_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire rlbr_pkg::cmd_t         cq_dout,
  input  wire rlbr_pkg::queue_flags_t cq_flags,
  output logic                        cq_pop,
  output logic                        empty,
  input  wire logic                   pop,
  output rlbr_pkg::result_t           result
);
  import rlbr_pkg::*;

  logic [7:0]        line_store [LINE_SLOTS * LINE_BYTES];
  logic [7:0]        rd_data;

  back_state_t       state;
  back_state_t       state_next;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] cur_addr_next;
  logic [LEN_W-1:0]  remain;
  logic [LEN_W-1:0]  remain_next;
  logic              cur_ready;
  logic              cur_ready_next;

  logic              issue;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] rd_addr;
  result_t           meta;

  logic              p1_valid;
  result_t           p1_meta;
  result_t           p1_result;

  result_t             obuf [OB_DEPTH];
  logic [OB_PTR_W-1:0] ob_wr;
  logic [OB_PTR_W-1:0] ob_rd;
  logic [OB_CNT_W-1:0] ob_count;
  logic [OB_CNT_W:0]   ob_used;
  logic                room;
  logic                ob_pop;

  assign ob_used = {1'b0, ob_count} + (OB_CNT_W + 1)'(p1_valid);
  assign room    = ob_used < (OB_CNT_W + 1)'(OB_DEPTH);
  assign empty   = (ob_count == '0);
  assign ob_pop  = pop && !empty;
  assign result  = obuf[ob_rd];

  always_comb begin
    state_next     = state;
    cur_addr_next  = cur_addr;
    remain_next    = remain;
    cur_ready_next = cur_ready;
    issue          = 1'b0;
    cq_pop         = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    rd_addr        = cq_dout.addr;
    meta           = '0;
    case (state)
      BK_IDLE: begin
        if (room && !cq_flags.empty) begin
          issue  = 1'b1;
          cq_pop = 1'b1;
          case (cq_dout.kind)
            CMD_POP: begin
              mem_re          = 1'b1;
              meta.status     = ST_LINE;
              meta.last       = (cq_dout.len == LEN_W'(1));
              meta.line_ready = cq_dout.ready;
              cur_addr_next   = cq_dout.addr + ADDR_W'(1);
              remain_next     = cq_dout.len - LEN_W'(1);
              cur_ready_next  = cq_dout.ready;
              if (cq_dout.len != LEN_W'(1)) begin
                state_next = BK_STREAM;
              end
            end
            CMD_REFUSE: begin
              meta.status     = ST_REFUSE;
              meta.last       = 1'b1;
              meta.line_ready = cq_dout.ready;
            end
            default: begin
              mem_we          = cq_dout.we;
              meta.status     = ST_ACCEPT;
              meta.last       = 1'b1;
              meta.line_ready = cq_dout.ready;
            end
          endcase
        end
      end
      BK_STREAM: begin
        rd_addr = cur_addr;
        if (room) begin
          issue           = 1'b1;
          mem_re          = 1'b1;
          meta.status     = ST_LINE;
          meta.last       = (remain == LEN_W'(1));
          meta.line_ready = cur_ready;
          cur_addr_next   = cur_addr + ADDR_W'(1);
          remain_next     = remain - LEN_W'(1);
          if (remain == LEN_W'(1)) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_addr  <= cur_addr_next;
    remain    <= remain_next;
    cur_ready <= cur_ready_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[cq_dout.addr] <= cq_dout.data;
    end
    if (mem_re) begin
      rd_data <= line_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= issue;
    end
    if (issue) begin
      p1_meta <= meta;
    end
  end

  always_comb begin
    p1_result = p1_meta;
    p1_result.line_byte = (p1_meta.status == ST_LINE) ? rd_data : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (p1_valid) begin
      obuf[ob_wr] <= p1_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr    <= '0;
      ob_rd    <= '0;
      ob_count <= '0;
    end else begin
      if (p1_valid) begin
        ob_wr <= ob_wr + OB_PTR_W'(1);
      end
      if (ob_pop) begin
        ob_rd <= ob_rd + OB_PTR_W'(1);
      end
      if (p1_valid && !ob_pop) begin
        ob_count <= ob_count + OB_CNT_W'(1);
      end else if (ob_pop && !p1_valid) begin
        ob_count <= ob_count - OB_CNT_W'(1);
      end
    end
  end

  // result buffer never overfills
  assert property (@(posedge clk) disable iff (rst)
    ob_count <= OB_CNT_W'(OB_DEPTH))
    else $error("result buffer overflow");

  // a running stream always has bytes left
  assert property (@(posedge clk) disable iff (rst)
    (state == BK_STREAM) |-> (remain != '0))
    else $error("stream with nothing left");

  // no new command is taken while a line streams out
  assert property (@(posedge clk) disable iff (rst)
    (state == BK_STREAM) |-> !cq_pop)
    else $error("command taken during stream");

  // every result that is not a line byte closes its request
  assert property (@(posedge clk) disable iff (rst)
    (p1_valid && (p1_meta.status != ST_LINE)) |-> p1_meta.last)
    else $error("non-line result without last");

endmodule
`default_nettype wire
